>>> hdl/mtne_pkg.sv
package mtne_pkg;

  localparam int unsigned MaxNotesDef = 4096;
  localparam int unsigned TableDepth  = 2048;
  localparam int unsigned TableAw     = 11;

  localparam logic [15:0] TpqReset    = 16'd480;
  localparam logic [23:0] TempoReset  = 24'd500000;
  localparam logic [39:0] TickReset   = 40'd68266666;
  localparam logic [39:0] MinLenUs    = 40'd10000;
  localparam logic [39:0] DrumLenUs   = 40'd50000;
  localparam logic [57:0] TimeMax     = 58'h0FFFFFFFFFFFFFF;

  localparam logic [7:0] StMeta  = 8'hFF;
  localparam logic [7:0] StSysex = 8'hF0;
  localparam logic [7:0] StEsc   = 8'hF7;
  localparam logic [3:0] HiNoteOn  = 4'h9;
  localparam logic [3:0] HiNoteOff = 4'h8;
  localparam logic [3:0] HiProg    = 4'hC;
  localparam logic [3:0] HiPress   = 4'hD;
  localparam logic [3:0] HiSys     = 4'hF;
  localparam logic [7:0] MetaTempo = 8'h51;
  localparam logic [3:0] DrumChan  = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_t;

  typedef struct packed {
    logic [6:0]  note_number;
    logic [39:0] start_us;
    logic [39:0] length_us;
    logic        is_drum;
  } out_t;

endpackage

>>> hdl/midi_track_note_extractor_top.sv
// Track-chunk byte parser producing note records.
// Input channel: one track body byte per request (in_valid_i/in_stall_o),
// with track_start marking the first byte of a track. Output channel: one
// note record per request (out_valid_o/out_stall_i), held in an output
// register so the next byte can be taken while a record waits.
// A plain byte is accepted in the idle state. A completed delta time runs
// through the accept, the delta * tick-length multiply and the saturating add.
// A note-off / drum hit reads the start table at accept, then loads the
// record; the load waits only while the previous record is still stalled.
// A tempo event or a ticks_per_quarter write recomputes the tick length
// with a 40-step bit-serial divider while the input is stalled.
// The note start table (2048 x 40 bit RAM) is zeroed by a clear pass after
// reset and before a byte flagged track_start is accepted on a used table.
// Reset clears the parser, tempo (500000 us), ticks_per_quarter (480),
// the record count and the output valid flag.
module midi_track_note_extractor_top #(
  parameter int unsigned MAX_NOTES = mtne_pkg::MaxNotesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mtne_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mtne_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i
);
  import mtne_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_NOTES + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_REC   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;

  localparam logic [2:0] PH_DELTA = 3'd0;
  localparam logic [2:0] PH_STAT  = 3'd1;
  localparam logic [2:0] PH_KEY   = 3'd2;
  localparam logic [2:0] PH_VEL   = 3'd3;
  localparam logic [2:0] PH_MTYPE = 3'd4;
  localparam logic [2:0] PH_LEN   = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;
  localparam logic [2:0] PH_TEMPO = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [2:0]  phase_q;
  logic [7:0]  rs_q;
  logic [27:0] vv_q;
  logic [2:0]  vb_q;
  logic [6:0]  hn_q;
  logic [7:0]  mk_q;
  logic [27:0] sl_q;
  logic [23:0] tempo_q;
  logic [39:0] tick_q;
  logic [55:0] time_q;
  logic [CntW-1:0] rec_cnt_q;
  logic [15:0] tpq_q;
  logic        pend_q;
  logic        clean_q;
  logic [TableAw-1:0] clr_cnt_q;
  logic [27:0] delta_q;
  logic [47:0] hi_q, lo_q;
  logic        rec_drum_q;
  logic [39:0] rd_q;
  logic        out_valid_q;
  out_t        out_q;

  logic [39:0] mem [TableDepth];

  // parse scratch
  logic [2:0]  p_ph;
  logic [7:0]  p_rs;
  logic [27:0] p_vv;
  logic [2:0]  p_vb;
  logic [6:0]  p_hn;
  logic [7:0]  p_mk;
  logic [27:0] p_sl;
  logic [23:0] p_tempo;
  logic [27:0] p_delta;
  logic        vdone;
  logic        ev_delta, ev_tempo, ev_wr, ev_rec, ev_drum, ev_on;
  logic [7:0]  b;
  logic [27:0] len_v;
  logic [3:0]  hi_nib;
  logic [TableAw-1:0] idx;

  logic        accept;
  logic        start_div;
  logic        div_done;
  logic [39:0] div_quo;
  logic [15:0] divisor;
  logic        rec_load;
  logic [39:0] now_us;
  logic [39:0] len_us;
  logic [57:0] prod, sum;
  logic [55:0] time_add;
  logic        mem_we;
  logic [TableAw-1:0] mem_wa;
  logic [39:0] mem_wd;
  logic        room;

  assign b      = in_data_i.data_byte;
  assign now_us = time_q[55:16];
  assign room   = rec_cnt_q < CntW'(MAX_NOTES);

  always_comb begin
    p_ph = phase_q; p_rs = rs_q; p_vv = vv_q; p_vb = vb_q;
    p_hn = hn_q; p_mk = mk_q; p_sl = sl_q; p_tempo = tempo_q;
    p_delta = '0; vdone = 1'b0; len_v = '0; hi_nib = '0; idx = '0;
    ev_delta = 1'b0; ev_tempo = 1'b0; ev_wr = 1'b0; ev_rec = 1'b0;
    ev_drum = 1'b0; ev_on = 1'b0;
    if (in_data_i.track_start) begin
      p_ph = PH_DELTA; p_rs = '0; p_vv = '0; p_vb = '0;
      p_hn = '0; p_mk = '0; p_sl = '0;
    end
    if (p_ph == PH_STAT) begin
      if (b[7]) begin
        p_rs = b;
      end
      hi_nib = p_rs[7:4];
      if (hi_nib == HiNoteOn || hi_nib == HiNoteOff) begin
        p_ph = PH_KEY;
      end else if (p_rs == StMeta) begin
        p_ph = PH_MTYPE;
      end else if (p_rs == StSysex || p_rs == StEsc) begin
        p_mk = '0; p_vv = '0; p_vb = '0;
        p_ph = PH_LEN;
      end else begin
        p_sl = (hi_nib == HiProg || hi_nib == HiPress || hi_nib == HiSys) ?
               28'd1 : 28'd2;
        p_ph = PH_SKIP;
      end
    end
    if (!(phase_q == PH_STAT && !in_data_i.track_start && b[7])) begin
      case (p_ph)
        PH_DELTA, PH_LEN: begin
          p_vv = {p_vv[20:0], b[6:0]};
          p_vb = p_vb + 3'd1;
          if (!b[7]) begin
            p_vb = '0; vdone = 1'b1;
          end else if (p_vb >= 3'd5) begin
            p_vv = '0; p_vb = '0; vdone = 1'b1;
          end
          if (vdone) begin
            len_v = p_vv;
            p_vv  = '0;
            if (p_ph == PH_DELTA) begin
              p_delta  = len_v;
              ev_delta = 1'b1;
              p_ph     = PH_STAT;
            end else if (len_v == '0) begin
              p_ph = PH_DELTA;
            end else if (p_mk == MetaTempo && len_v == 28'd3 && p_rs == StMeta) begin
              p_sl = 28'd3;
              p_ph = PH_TEMPO;
            end else begin
              p_sl = len_v;
              p_ph = PH_SKIP;
            end
          end
        end
        PH_KEY: begin
          p_hn = b[6:0];
          p_ph = PH_VEL;
        end
        PH_VEL: begin
          p_ph  = PH_DELTA;
          idx   = {p_rs[3:0], p_hn};
          ev_on = (p_rs[7:4] == HiNoteOn) && (b != 8'd0);
          if (ev_on) begin
            if (p_rs[3:0] != DrumChan) begin
              ev_wr = 1'b1;
            end else if (room) begin
              ev_rec = 1'b1; ev_drum = 1'b1;
            end
          end else if (p_rs[3:0] != DrumChan && room) begin
            ev_rec = 1'b1;
          end
        end
        PH_MTYPE: begin
          p_mk = b; p_vv = '0; p_vb = '0;
          p_ph = PH_LEN;
        end
        PH_TEMPO: begin
          p_vv = {4'd0, p_vv[15:0], b};
          if (p_sl != '0) begin
            p_sl = p_sl - 28'd1;
          end
          if (p_sl == '0) begin
            p_tempo  = p_vv[23:0];
            p_vv     = '0;
            ev_tempo = 1'b1;
            p_ph     = PH_DELTA;
          end
        end
        default: begin
          if (p_sl != '0) begin
            p_sl = p_sl - 28'd1;
          end
          if (p_sl == '0) begin
            p_ph = PH_DELTA;
          end
        end
      endcase
    end
  end

  assign in_stall_o = !(state_q == S_IDLE && !pend_q && !cfg_we_i &&
                        !(in_data_i.track_start && !clean_q));
  assign accept     = in_valid_i && !in_stall_o;
  assign start_div  = state_q == S_IDLE && pend_q;
  assign divisor    = (tpq_q == '0) ? TpqReset : tpq_q;
  assign rec_load   = state_q == S_REC && (!out_valid_q || !out_stall_i);

  mtne_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_div),
    .dividend_i ({tempo_q, 16'd0}),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_cnt_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (pend_q) begin
          state_d = S_DIV;
        end else if (in_valid_i && in_data_i.track_start && !clean_q && !cfg_we_i) begin
          state_d = S_CLEAR;
        end else if (accept) begin
          if (ev_delta) state_d = S_MUL;
          else if (ev_rec) state_d = S_REC;
        end
      end
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = S_IDLE;
      S_REC:   if (rec_load) state_d = S_IDLE;
      S_DIV:   if (div_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign prod     = {2'd0, hi_q[35:0], 20'd0} + {10'd0, lo_q};
  assign sum      = {2'd0, time_q} + prod;
  assign time_add = (hi_q[47:36] != '0 || sum >= TimeMax) ? TimeMax[55:0] : sum[55:0];

  always_comb begin
    len_us = (now_us > rd_q) ? now_us - rd_q : '0;
    if (len_us < MinLenUs) len_us = MinLenUs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= PH_DELTA;
      rs_q        <= '0;
      vv_q        <= '0;
      vb_q        <= '0;
      hn_q        <= '0;
      mk_q        <= '0;
      sl_q        <= '0;
      tempo_q     <= TempoReset;
      tick_q      <= TickReset;
      time_q      <= '0;
      rec_cnt_q   <= '0;
      tpq_q       <= TpqReset;
      pend_q      <= 1'b0;
      clean_q     <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tpq_q  <= cfg_wdata_i;
        pend_q <= 1'b1;
      end else if (accept && ev_tempo) begin
        pend_q <= 1'b1;
      end else if (start_div) begin
        pend_q <= 1'b0;
      end
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + TableAw'(1);
        if (clr_cnt_q == '1) clean_q <= 1'b1;
      end
      if (accept) begin
        clean_q <= 1'b0;
        phase_q <= p_ph;
        rs_q    <= p_rs;
        vv_q    <= p_vv;
        vb_q    <= p_vb;
        hn_q    <= p_hn;
        mk_q    <= p_mk;
        sl_q    <= p_sl;
        tempo_q <= p_tempo;
        if (in_data_i.track_start) time_q <= '0;
        if (ev_rec) rec_cnt_q <= rec_cnt_q + CntW'(1);
      end
      if (state_q == S_ADD) time_q <= time_add;
      if (state_q == S_DIV && div_done) tick_q <= div_quo;
      if (rec_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      delta_q    <= p_delta;
      rec_drum_q <= ev_drum;
    end
    if (state_q == S_MUL) begin
      hi_q <= delta_q * tick_q[39:20];
      lo_q <= delta_q * tick_q[19:0];
    end
    if (rec_load) begin
      out_q.note_number <= hn_q;
      out_q.start_us    <= rec_drum_q ? now_us : rd_q;
      out_q.length_us   <= rec_drum_q ? DrumLenUs : len_us;
      out_q.is_drum     <= rec_drum_q;
    end
  end

  assign mem_we = (state_q == S_CLEAR) || (accept && ev_wr);
  assign mem_wa = (state_q == S_CLEAR) ? clr_cnt_q : idx;
  assign mem_wd = (state_q == S_CLEAR) ? '0 : now_us;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (accept && ev_rec) rd_q <= mem[idx];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> state_q == S_IDLE)
    else $error("input accepted outside idle");

  a_rec_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_REC)
    else $error("record without table read");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR || state_q == S_DIV) |-> in_stall_o)
    else $error("input open during clear or divide");

endmodule

>>> hdl/mtne_div.sv
module mtne_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [39:0] quotient_o
);
  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [15:0] rem_q;
  logic [15:0] div_q;
  logic [39:0] quo_q;
  logic [16:0] r2;
  logic        ge;
  logic [16:0] diff;

  assign r2   = {rem_q, quo_q[39]};
  assign ge   = r2 >= {1'b0, div_q};
  assign diff = r2 - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd39) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[15:0] : r2[15:0];
      quo_q <= {quo_q[38:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
